// ----- design/fra_pkg.sv -----
// shared types and constants for the four register alu executor
`default_nettype none

package fra_pkg;

	localparam int FRA_DATA_WIDTH = 32;
	localparam int FUNC_WIDTH     = 3;
	localparam int REG_IDX_WIDTH  = 2;
	localparam int IMM_WIDTH      = 32;
	localparam int PC_WIDTH       = 31;
	localparam int STATUS_WIDTH   = 2;
	localparam int OUT_VAL_WIDTH  = 32;
	localparam int NUM_REGS       = 4;
	localparam int S_TDATA_WIDTH  = 72;
	localparam int M_TDATA_WIDTH  = 72;

	typedef enum logic [FUNC_WIDTH-1:0] {
		FUNC_MOV = 3'd0,
		FUNC_ADD = 3'd1,
		FUNC_SUB = 3'd2,
		FUNC_MUL = 3'd3,
		FUNC_DIV = 3'd4,
		FUNC_INC = 3'd5,
		FUNC_DEC = 3'd6,
		FUNC_JNZ = 3'd7
	} func_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_OK         = 2'd0,
		ST_DIV_ZERO   = 2'd1,
		ST_NEG_TARGET = 2'd2
	} status_t;

	localparam logic [REG_IDX_WIDTH-1:0] REG_C = 2'd2;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef enum logic [2:0] {
		ALU_IDLE,
		ALU_SERIAL,
		ALU_MULT,
		ALU_DIVIDE,
		ALU_FIX,
		ALU_DONE
	} alu_state_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_DECODE,
		TOP_RUN,
		TOP_OUT
	} top_state_t;

endpackage

`default_nettype wire

// ----- design/fra_serial_alu.sv -----
// serial arithmetic unit: bit-serial add and subtract, radix-2 multiply and divide
`default_nettype none

module fra_serial_alu #(
	parameter int DATA_WIDTH = fra_pkg::FRA_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fra_pkg::alu_req_t     req,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);
	import fra_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W);

	alu_state_t     state_q, state_d;
	alu_op_t        op_q;
	logic [W-1:0]   x_q, y_q, r_q;
	logic           carry_q, neg_q;
	logic [CW-1:0]  cnt_q;

	logic           last;
	logic           y_bit, sum_bit, carry_next;
	logic [W-1:0]   mul_sum;
	logic [W:0]     trial, diff;
	logic           borrow;
	logic [W-1:0]   a_mag, b_mag;

	assign last       = (cnt_q == CW'(W - 1));
	assign y_bit      = y_q[0] ^ (op_q == ALU_SUB);
	assign sum_bit    = x_q[0] ^ y_bit ^ carry_q;
	assign carry_next = (x_q[0] & y_bit) | (x_q[0] & carry_q) | (y_bit & carry_q);
	assign mul_sum    = r_q + x_q;
	assign trial      = {r_q, x_q[W-1]};
	assign diff       = trial - {1'b0, y_q};
	assign borrow     = diff[W];
	assign a_mag      = a[W-1] ? (W'(0) - a) : a;
	assign b_mag      = b[W-1] ? (W'(0) - b) : b;

	assign done   = (state_q == ALU_DONE);
	assign result = (op_q == ALU_MUL) ? r_q : x_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ALU_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						ALU_ADD, ALU_SUB: state_d = ALU_SERIAL;
						ALU_MUL:          state_d = ALU_MULT;
						ALU_DIV:          state_d = ALU_DIVIDE;
						default:          state_d = ALU_IDLE;
					endcase
				end
			end
			ALU_SERIAL, ALU_MULT: begin
				if (last) state_d = ALU_DONE;
			end
			ALU_DIVIDE: begin
				if (last) state_d = ALU_FIX;
			end
			ALU_FIX:  state_d = ALU_DONE;
			ALU_DONE: state_d = ALU_IDLE;
			default:  state_d = ALU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ALU_IDLE) cnt_q <= '0;
			else if (!last)          cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ALU_IDLE: begin
				if (req.start) begin
					op_q    <= req.op;
					carry_q <= (req.op == ALU_SUB);
					r_q     <= '0;
					neg_q   <= a[W-1] ^ b[W-1];
					if (req.op == ALU_DIV) begin
						x_q <= a_mag;
						y_q <= b_mag;
					end else begin
						x_q <= a;
						y_q <= b;
					end
				end
			end
			ALU_SERIAL: begin
				x_q     <= {sum_bit, x_q[W-1:1]};
				y_q     <= {1'b0, y_q[W-1:1]};
				carry_q <= carry_next;
			end
			ALU_MULT: begin
				if (y_q[0]) r_q <= mul_sum;
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end
			ALU_DIVIDE: begin
				r_q <= borrow ? trial[W-1:0] : diff[W-1:0];
				x_q <= {x_q[W-2:0], ~borrow};
			end
			ALU_FIX: begin
				if (neg_q) x_q <= W'(0) - x_q;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/four_register_alu_executor.sv -----
// top level: register file, instruction sequencer and result register
//
// channel  dir  handshake           tdata fields, lowest bit up
// s_*      in   s_tvalid/s_tready   func, dest_reg, src_is_reg, src_reg, immediate, current_pc
// m_*      out  m_tvalid/m_tready   status, next_pc, written_value
//
// add, sub, mov, inc, dec and mul run through the serial unit, and div adds a sign fix step;
// the serial unit handles one bit per cycle
// jnz and division by zero skip the serial unit
// after reset all four registers read as zero through their valid bits
// a finished result waits in the output register; a new request is taken meanwhile
// and waits at the end of its run until that register is free
`default_nettype none

module four_register_alu_executor #(
	parameter int DATA_WIDTH = fra_pkg::FRA_DATA_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// func, dest_reg, src_is_reg, src_reg, immediate, current_pc, zero pad
	input  logic [fra_pkg::S_TDATA_WIDTH-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status, next_pc, written_value, zero pad
	output logic [fra_pkg::M_TDATA_WIDTH-1:0] m_tdata
);
	import fra_pkg::*;

	localparam int W = DATA_WIDTH;

	localparam int FUNC_LSB = 0;
	localparam int DEST_LSB = FUNC_LSB + FUNC_WIDTH;
	localparam int SISR_LSB = DEST_LSB + REG_IDX_WIDTH;
	localparam int SREG_LSB = SISR_LSB + 1;
	localparam int IMM_LSB  = SREG_LSB + REG_IDX_WIDTH;
	localparam int PC_LSB   = IMM_LSB + IMM_WIDTH;
	localparam int IN_BITS  = PC_LSB + PC_WIDTH;

	localparam int NPC_LSB  = STATUS_WIDTH;
	localparam int VAL_LSB  = NPC_LSB + PC_WIDTH;
	localparam int OUT_BITS = VAL_LSB + OUT_VAL_WIDTH;

	top_state_t                 state_q, state_d;
	logic                       accept;

	func_t                      func_q;
	logic [REG_IDX_WIDTH-1:0]   dest_q;
	logic                       src_is_reg_q;
	logic [IMM_WIDTH-1:0]       imm_q;
	logic [PC_WIDTH-1:0]        pc_q;
	logic [W-1:0]               rd_q, rs_q;
	logic                       c_nz_q;

	logic [W-1:0]               mem_q [NUM_REGS];
	logic [NUM_REGS-1:0]        valid_q;

	logic [W-1:0]               res_q;
	status_t                    status_q;
	logic [PC_WIDTH-1:0]        npc_q;

	logic                       m_valid_q;
	status_t                    out_status_q;
	logic [PC_WIDTH-1:0]        out_npc_q;
	logic [OUT_VAL_WIDTH-1:0]   out_val_q;

	logic [W-1:0]               imm_ext, operand;
	alu_req_t                   alu_req;
	logic [W-1:0]               alu_a, alu_b;
	status_t                    dec_status;
	logic [PC_WIDTH-1:0]        dec_npc;
	logic                       alu_done;
	logic [W-1:0]               alu_result;
	logic                       out_free;

	assign s_tready = (state_q == TOP_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_WIDTH - OUT_BITS){1'b0}}, out_val_q, out_npc_q, out_status_q};

	assign imm_ext = W'($signed(imm_q));
	assign operand = src_is_reg_q ? rs_q : imm_ext;

	// instruction decode
	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = ALU_ADD;
		alu_a         = rd_q;
		alu_b         = operand;
		dec_status    = ST_OK;
		dec_npc       = pc_q + PC_WIDTH'(1);
		unique case (func_q)
			FUNC_MOV: begin
				alu_req.start = 1'b1;
				alu_a         = '0;
			end
			FUNC_ADD: alu_req.start = 1'b1;
			FUNC_SUB: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_SUB;
			end
			FUNC_MUL: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_MUL;
			end
			FUNC_DIV: begin
				alu_req.op = ALU_DIV;
				if (operand == '0) dec_status = ST_DIV_ZERO;
				else               alu_req.start = 1'b1;
			end
			FUNC_INC: begin
				alu_req.start = 1'b1;
				alu_b         = W'(1);
			end
			FUNC_DEC: begin
				alu_req.start = 1'b1;
				alu_req.op    = ALU_SUB;
				alu_b         = W'(1);
			end
			FUNC_JNZ: begin
				if (c_nz_q) begin
					if (imm_q[IMM_WIDTH-1]) dec_status = ST_NEG_TARGET;
					else                    dec_npc = imm_q[PC_WIDTH-1:0];
				end
			end
			default: begin
			end
		endcase
		if (state_q != TOP_DECODE) alu_req.start = 1'b0;
	end

	fra_serial_alu #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.done   (alu_done),
		.result (alu_result)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (accept) state_d = TOP_DECODE;
			end
			TOP_DECODE: begin
				if (alu_req.start) state_d = TOP_RUN;
				else               state_d = TOP_OUT;
			end
			TOP_RUN: begin
				if (alu_done) state_d = TOP_OUT;
			end
			TOP_OUT: begin
				if (out_free) state_d = TOP_IDLE;
			end
			default: state_d = TOP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= TOP_IDLE;
			m_valid_q <= 1'b0;
			valid_q   <= '0;
			c_nz_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == TOP_OUT && out_free) begin
				m_valid_q       <= 1'b1;
				valid_q[dest_q] <= 1'b1;
				if (dest_q == REG_C) c_nz_q <= (res_q != '0);
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// register file, read ports registered
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= valid_q[s_tdata[SISR_LSB-1:DEST_LSB]] ?
			        mem_q[s_tdata[SISR_LSB-1:DEST_LSB]] : '0;
			rs_q <= valid_q[s_tdata[IMM_LSB-1:SREG_LSB]] ?
			        mem_q[s_tdata[IMM_LSB-1:SREG_LSB]] : '0;
		end
		if (state_q == TOP_OUT && out_free) mem_q[dest_q] <= res_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= func_t'(s_tdata[DEST_LSB-1:FUNC_LSB]);
			dest_q       <= s_tdata[SISR_LSB-1:DEST_LSB];
			src_is_reg_q <= s_tdata[SISR_LSB];
			imm_q        <= s_tdata[PC_LSB-1:IMM_LSB];
			pc_q         <= s_tdata[IN_BITS-1:PC_LSB];
		end
		if (state_q == TOP_DECODE) begin
			status_q <= dec_status;
			npc_q    <= dec_npc;
			res_q    <= rd_q;
		end
		if (state_q == TOP_RUN && alu_done) res_q <= alu_result;
		if (state_q == TOP_OUT && out_free) begin
			out_status_q <= status_q;
			out_npc_q    <= npc_q;
			out_val_q    <= OUT_VAL_WIDTH'($signed(res_q));
		end
	end

endmodule

`default_nettype wire

// ----- dv/four_register_alu_executor_tb.sv -----
// testbench for the four register alu executor: stream stimulus, scoreboard and predictor
`default_nettype none

module four_register_alu_executor_tb;
	import fra_pkg::*;

	typedef struct packed {
		func_t                    func;
		logic [REG_IDX_WIDTH-1:0] dest;
		logic                     src_is_reg;
		logic [REG_IDX_WIDTH-1:0] src;
		logic [IMM_WIDTH-1:0]     imm;
		logic [PC_WIDTH-1:0]      pc;
	} instr_t;

	typedef struct packed {
		status_t                  status;
		logic [PC_WIDTH-1:0]      npc;
		logic [OUT_VAL_WIDTH-1:0] wval;
	} outcome_t;

	localparam int NUM_RANDOM = 580;
	localparam int HOLD_CYCLES = 300;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [M_TDATA_WIDTH-1:0] m_tdata;

	instr_t   instr_q[$];
	outcome_t outcome_q[$];
	logic [FRA_DATA_WIDTH-1:0] arch_regs[NUM_REGS];

	logic req_taken = 1'b0;
	int   hold_left = 0;
	int   holds_done = 0;
	int   gap_left = 0;
	int   burst_left = 0;
	int   rx_mode = 0;
	int   rx_mode_left = 0;
	int   n_accepted = 0;
	int   n_checked = 0;
	int   n_errors = 0;
	int   n_div_zero = 0;
	int   n_neg_target = 0;
	int   n_jumps = 0;
	int   n_stalled = 0;
	int   func_seen[8];

	four_register_alu_executor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		n_errors++;
		if (n_errors <= 40) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	function automatic instr_t mk_instr(input func_t f, input int d, input bit sir, input int s,
			input logic [IMM_WIDTH-1:0] imm, input logic [PC_WIDTH-1:0] pc);
		instr_t ins;
		ins.func = f;
		ins.dest = REG_IDX_WIDTH'(d);
		ins.src_is_reg = sir;
		ins.src = REG_IDX_WIDTH'(s);
		ins.imm = imm;
		ins.pc = pc;
		return ins;
	endfunction

	function automatic logic [S_TDATA_WIDTH-1:0] pack_instr(input instr_t ins);
		return {1'b0, ins.pc, ins.imm, ins.src, ins.src_is_reg, ins.dest, ins.func};
	endfunction

	function automatic instr_t unpack_instr(input logic [S_TDATA_WIDTH-1:0] bus);
		instr_t ins;
		ins.func = func_t'(bus[2:0]);
		ins.dest = bus[4:3];
		ins.src_is_reg = bus[5];
		ins.src = bus[7:6];
		ins.imm = bus[39:8];
		ins.pc = bus[70:40];
		return ins;
	endfunction

	// architectural effect of one instruction on the register copy
	function automatic outcome_t execute_instr(input instr_t ins);
		logic [FRA_DATA_WIDTH-1:0] dval;
		logic [FRA_DATA_WIDTH-1:0] opnd;
		longint dividend;
		longint divisor;
		longint quot;
		outcome_t res;
		dval = arch_regs[ins.dest];
		opnd = ins.src_is_reg ? arch_regs[ins.src] : ins.imm;
		res.status = ST_OK;
		res.npc = ins.pc + PC_WIDTH'(1);
		case (ins.func)
			FUNC_MOV: dval = opnd;
			FUNC_ADD: dval = dval + opnd;
			FUNC_SUB: dval = dval - opnd;
			FUNC_MUL: dval = dval * opnd;
			FUNC_DIV: begin
				if (opnd == '0) begin
					res.status = ST_DIV_ZERO;
				end else begin
					dividend = longint'($signed(dval));
					divisor = longint'($signed(opnd));
					quot = dividend / divisor;
					dval = quot[FRA_DATA_WIDTH-1:0];
				end
			end
			FUNC_INC: dval = dval + FRA_DATA_WIDTH'(1);
			FUNC_DEC: dval = dval - FRA_DATA_WIDTH'(1);
			default: begin
				if (arch_regs[REG_C] != '0) begin
					if (ins.imm[IMM_WIDTH-1]) begin
						res.status = ST_NEG_TARGET;
					end else begin
						res.npc = ins.imm[PC_WIDTH-1:0];
					end
				end
			end
		endcase
		arch_regs[ins.dest] = dval;
		res.wval = dval;
		return res;
	endfunction

	function automatic logic [IMM_WIDTH-1:0] rand_imm();
		logic [IMM_WIDTH-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 32) - 16;
			1: begin
				case ($urandom_range(0, 4))
					0: v = 32'h0000_0000;
					1: v = 32'h0000_0001;
					2: v = 32'hffff_ffff;
					3: v = 32'h7fff_ffff;
					default: v = 32'h8000_0001;
				endcase
			end
			2: v = $urandom_range(0, 1000);
			default: v = $urandom;
		endcase
		if (v == 32'h8000_0000) begin
			v = 32'h8000_0001;
		end
		return v;
	endfunction

	function automatic instr_t rand_instr();
		instr_t ins;
		logic [PC_WIDTH-1:0] pc;
		case ($urandom_range(0, 15))
			0: pc = '1;
			1: pc = '0;
			default: pc = PC_WIDTH'($urandom);
		endcase
		if ($urandom_range(0, 9) == 0) begin
			// keep register c toggling between zero and nonzero for jnz
			ins = mk_instr(FUNC_MOV, int'(REG_C), 1'b0, $urandom_range(0, 3),
				($urandom_range(0, 1) == 0) ? '0 : rand_imm(), pc);
		end else begin
			ins = mk_instr(func_t'($urandom_range(0, 7)), $urandom_range(0, 3),
				1'($urandom_range(0, 1)), $urandom_range(0, 3), rand_imm(), pc);
		end
		return ins;
	endfunction

	// sender: bursts of requests separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (gap_left > 0 && hold_left == 0) begin
				gap_left = gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (instr_q.size() > 0) begin
				s_tdata <= pack_instr(instr_q.pop_front());
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern redrawn from three modes when its counter runs out, plus two long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (holds_done < 2 && n_accepted >= 150 + 250 * holds_done) begin
				hold_left <= HOLD_CYCLES;
				holds_done <= holds_done + 1;
				m_tready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_mode_left = 64;
				end
				rx_mode_left = rx_mode_left - 1;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// request capture, prediction and result check
	always @(posedge clk) begin
		instr_t   ins;
		outcome_t exp_res;
		outcome_t got;
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && !s_tready) begin
				n_stalled++;
			end
			if (s_tvalid && s_tready) begin
				ins = unpack_instr(s_tdata);
				exp_res = execute_instr(ins);
				outcome_q.push_back(exp_res);
				n_accepted++;
				func_seen[ins.func]++;
				if (exp_res.status == ST_DIV_ZERO) n_div_zero++;
				if (exp_res.status == ST_NEG_TARGET) n_neg_target++;
				if (ins.func == FUNC_JNZ && exp_res.status == ST_OK
						&& exp_res.npc != ins.pc + PC_WIDTH'(1)) begin
					n_jumps++;
				end
			end
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tdata[1:0]);
				got.npc = m_tdata[32:2];
				got.wval = m_tdata[64:33];
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf(
						"result with nothing expected: status %0d pc %h val %h",
						got.status, got.npc, got.wval));
				end else begin
					exp_res = outcome_q.pop_front();
					n_checked++;
					if (got.status != exp_res.status || got.npc != exp_res.npc
							|| got.wval != exp_res.wval) begin
						report_mismatch($sformatf(
							"result %0d: status %0d/%0d next_pc %h/%h value %h/%h (got/exp)",
							n_checked, got.status, exp_res.status, got.npc, exp_res.npc,
							got.wval, exp_res.wval));
					end
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("timeout at %0t", $time);
		$display("status: fail");
		$finish;
	end

	initial begin
		for (int i = 0; i < NUM_REGS; i++) arch_regs[i] = '0;
		for (int i = 0; i < 8; i++) func_seen[i] = 0;

		// directed part: wrap edges, division corners, jump cases, pc wrap
		instr_q.push_back(mk_instr(FUNC_MOV, 0, 1'b0, 0, 32'h7fff_ffff, 31'd0));
		instr_q.push_back(mk_instr(FUNC_INC, 0, 1'b0, 0, 32'h0, 31'd1));
		instr_q.push_back(mk_instr(FUNC_DEC, 0, 1'b1, 3, 32'hdead_beef, 31'd2));
		instr_q.push_back(mk_instr(FUNC_INC, 0, 1'b0, 0, 32'h0, 31'd3));
		instr_q.push_back(mk_instr(FUNC_MOV, 1, 1'b0, 0, 32'hffff_ffff, 31'd4));
		instr_q.push_back(mk_instr(FUNC_DIV, 0, 1'b1, 1, 32'h0, 31'd5));
		instr_q.push_back(mk_instr(FUNC_DIV, 0, 1'b0, 2, 32'h0, 31'd6));
		instr_q.push_back(mk_instr(FUNC_DIV, 1, 1'b1, 3, 32'h5, 31'd7));
		instr_q.push_back(mk_instr(FUNC_MOV, 3, 1'b0, 0, -32'sd7, 31'd8));
		instr_q.push_back(mk_instr(FUNC_DIV, 3, 1'b0, 0, 32'd2, 31'd9));
		instr_q.push_back(mk_instr(FUNC_MUL, 3, 1'b0, 0, 32'h7fff_ffff, 31'd10));
		instr_q.push_back(mk_instr(FUNC_SUB, 2, 1'b0, 0, 32'h8000_0001, 31'd11));
		instr_q.push_back(mk_instr(FUNC_ADD, 2, 1'b0, 0, 32'h7fff_ffff, 31'd12));
		instr_q.push_back(mk_instr(FUNC_JNZ, 1, 1'b1, 2, 32'h7fff_ffff, 31'd13));
		instr_q.push_back(mk_instr(FUNC_JNZ, 0, 1'b0, 0, 32'hffff_ffff, 31'h7fff_ffff));
		instr_q.push_back(mk_instr(FUNC_MOV, 2, 1'b0, 3, 32'h0, 31'd14));
		instr_q.push_back(mk_instr(FUNC_JNZ, 2, 1'b0, 0, -32'sd5, 31'd15));
		instr_q.push_back(mk_instr(FUNC_JNZ, 3, 1'b1, 1, 32'd100, 31'd16));
		instr_q.push_back(mk_instr(FUNC_ADD, 1, 1'b1, 3, 32'h1234_5678, 31'h7fff_ffff));
		instr_q.push_back(mk_instr(FUNC_MOV, 0, 1'b1, 0, 32'h0, 31'd17));
		instr_q.push_back(mk_instr(FUNC_INC, 1, 1'b1, 2, 32'h8000_0001, 31'd18));
		instr_q.push_back(mk_instr(FUNC_MOV, 2, 1'b0, 0, 32'd1, 31'd19));
		instr_q.push_back(mk_instr(FUNC_JNZ, 3, 1'b0, 0, 32'd0, 31'd20));
		for (int i = 0; i < NUM_RANDOM; i++) begin
			instr_q.push_back(rand_instr());
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (instr_q.size() != 0 || s_tvalid || outcome_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (60) @(posedge clk);

		$display("%0d requests taken, %0d results checked, %0d input stall cycles",
			n_accepted, n_checked, n_stalled);
		$display("mov %0d add %0d sub %0d mul %0d div %0d inc %0d dec %0d jnz %0d;%s%0d %s%0d %s%0d",
			func_seen[0], func_seen[1], func_seen[2], func_seen[3], func_seen[4],
			func_seen[5], func_seen[6], func_seen[7], " div by zero ", n_div_zero,
			"negative target ", n_neg_target, "jumps taken ", n_jumps);
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
